// ===== sv/vqst_pkg.sv =====
// Package for the venue quote sync table: sizes, codes and the structs passed
// between the configuration block, the table core and the top level.
// No dependencies.
`default_nettype none

package vqst_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int NUM_ID_REGS = 4;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ID_W        = 8;
    localparam int TS_W        = 63;
    localparam int PX_W        = 32;
    localparam int CNT_W       = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_ORDER   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic {
        REQ_UPDATE = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req;

    typedef enum logic [2:0] {
        REG_ID0   = 3'd0,
        REG_ID1   = 3'd1,
        REG_ID2   = 3'd2,
        REG_ID3   = 3'd3,
        REG_COUNT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [NUM_SLOTS-1:0][ID_W-1:0] ids;
        logic [CNT_W-1:0]               count;
    } t_cfg;

    typedef struct packed {
        t_req                    req_type;
        logic [ID_W-1:0]         venue_key;
        logic [TS_W-1:0]         sample_time;
        logic [TS_W-1:0]         receipt_time;
        logic [TS_W-1:0]         exchange_time;
        logic signed [PX_W-1:0]  bid_ticks;
        logic signed [PX_W-1:0]  ask_ticks;
    } t_item;

    typedef struct packed {
        t_status                 status;
        logic                    venue_seen;
        logic signed [PX_W-1:0]  stored_bid;
        logic signed [PX_W-1:0]  stored_ask;
        logic [TS_W-1:0]         stored_receipt;
        logic [TS_W-1:0]         stored_exchange;
        logic [TS_W-1:0]         stored_sample;
        logic                    global_valid;
        logic [TS_W-1:0]         global_sample;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/vqst_cfg.sv =====
// APB register block: venue ids of the table slots and the active slot count.
// Depends on vqst_pkg.
`default_nettype none

module vqst_cfg
    import vqst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [NUM_ID_REGS-1:0][ID_W-1:0] r_ids;
    logic [CNT_W-1:0]                 r_count;
    logic                             wr_en;
    t_reg_idx                         reg_idx;
    logic [1:0]                       id_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign id_sel  = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ID_REGS; i++) begin
                r_ids[i] <= ID_W'(i);
            end
            r_count <= CNT_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx) inside
                REG_ID0, REG_ID1, REG_ID2, REG_ID3: begin
                    if (int'(id_sel) < NUM_SLOTS) begin
                        r_ids[id_sel] <= pwdata[ID_W-1:0];
                    end
                end
                REG_COUNT: begin
                    r_count <= pwdata[CNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx) inside
            REG_ID0, REG_ID1, REG_ID2, REG_ID3: prdata = DATA_W'(r_ids[id_sel]);
            REG_COUNT:                          prdata = DATA_W'(r_count);
            default:                            prdata = '0;
        endcase
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_ids
        if (g < NUM_ID_REGS) begin : g_reg
            assign o_cfg.ids[g] = r_ids[g];
        end else begin : g_fixed
            assign o_cfg.ids[g] = ID_W'(g % 256);
        end
    end

    assign o_cfg.count = r_count;

endmodule

`default_nettype wire

// ===== sv/vqst_core.sv =====
// Slot table with its checks: key match, timestamp ordering, table and global
// latest update, and the result record of one item. Depends on vqst_pkg.
`default_nettype none

module vqst_core
    import vqst_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_result
);

    logic [NUM_SLOTS-1:0]   r_seen;
    logic [TS_W-1:0]        r_rcpt [NUM_SLOTS];
    logic [TS_W-1:0]        r_exch [NUM_SLOTS];
    logic [TS_W-1:0]        r_samp [NUM_SLOTS];
    logic [PX_W-1:0]        r_bid  [NUM_SLOTS];
    logic [PX_W-1:0]        r_ask  [NUM_SLOTS];
    logic                   r_latest_valid;
    logic [TS_W-1:0]        r_latest_sample;

    logic                   hit;
    logic [SLOT_W-1:0]      idx;
    logic                   accept;
    logic                   wr;
    t_status                status;
    logic                   cur_seen;
    logic [TS_W-1:0]        cur_rcpt;
    logic [TS_W-1:0]        cur_samp;

    always_comb begin
        hit = 1'b0;
        idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if ((i < int'(i_cfg.count)) && (i_cfg.ids[i] == i_item.venue_key)) begin
                hit = 1'b1;
                idx = SLOT_W'(i);
            end
        end
    end

    assign cur_seen = r_seen[idx];
    assign cur_rcpt = r_rcpt[idx];
    assign cur_samp = r_samp[idx];

    always_comb begin
        accept = 1'b0;
        if (i_item.req_type == REQ_QUERY) begin
            status = hit ? ST_OK : ST_UNKNOWN;
        end else if (i_item.receipt_time > i_item.sample_time) begin
            status = ST_INVALID;
        end else if (r_latest_valid && (i_item.sample_time < r_latest_sample)) begin
            status = ST_ORDER;
        end else if (!hit) begin
            status = ST_UNKNOWN;
        end else if (cur_seen && ((i_item.sample_time < cur_samp)
                               || (i_item.receipt_time < cur_rcpt))) begin
            status = ST_ORDER;
        end else begin
            status = ST_OK;
            accept = 1'b1;
        end
    end

    assign wr = i_fire && accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen          <= '0;
            r_latest_valid  <= 1'b0;
            r_latest_sample <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_rcpt[i] <= '0;
                r_exch[i] <= '0;
                r_samp[i] <= '0;
                r_bid[i]  <= '0;
                r_ask[i]  <= '0;
            end
        end else if (wr) begin
            r_seen[idx]     <= 1'b1;
            r_rcpt[idx]     <= i_item.receipt_time;
            r_exch[idx]     <= i_item.exchange_time;
            r_samp[idx]     <= i_item.sample_time;
            r_bid[idx]      <= i_item.bid_ticks;
            r_ask[idx]      <= i_item.ask_ticks;
            r_latest_valid  <= 1'b1;
            r_latest_sample <= i_item.sample_time;
        end
    end

    always_comb begin
        o_result.status        = status;
        o_result.global_valid  = accept || r_latest_valid;
        o_result.global_sample = accept ? i_item.sample_time : r_latest_sample;
        if (!hit) begin
            o_result.venue_seen      = 1'b0;
            o_result.stored_bid      = '0;
            o_result.stored_ask      = '0;
            o_result.stored_receipt  = '0;
            o_result.stored_exchange = '0;
            o_result.stored_sample   = '0;
        end else if (accept) begin
            o_result.venue_seen      = 1'b1;
            o_result.stored_bid      = i_item.bid_ticks;
            o_result.stored_ask      = i_item.ask_ticks;
            o_result.stored_receipt  = i_item.receipt_time;
            o_result.stored_exchange = i_item.exchange_time;
            o_result.stored_sample   = i_item.sample_time;
        end else begin
            o_result.venue_seen      = cur_seen;
            o_result.stored_bid      = r_bid[idx];
            o_result.stored_ask      = r_ask[idx];
            o_result.stored_receipt  = cur_rcpt;
            o_result.stored_exchange = r_exch[idx];
            o_result.stored_sample   = cur_samp;
        end
    end

endmodule

`default_nettype wire

// ===== sv/venue_quote_sync_table_top.sv =====
// Venue quote sync table: per-venue latest quote store with ordering checks.
// Input channel i_in_valid / o_in_ready carries one update or query per transfer;
// output channel o_out_valid / i_out_ready carries one result per input item.
// Venue ids of the slots and the active slot count are set over the APB port
// (pready always high); the user must write them only while no item is in
// flight, as the block itself does not enforce this.
// An accepted item is held in the input register; the core checks it and
// its result is captured in the output register, which drives o_out_valid.
// Throughput: one item per cycle while the output register is free; the checks
// and the table write are a single pass of parallel slot compares between the
// two registers, so the next item always sees the table as updated by this one.
// Reset (synchronous, active low) clears the slot table, the global latest
// sample and the valid flags of both pipeline registers; slot ids return to
// 0..3, count to 1.
// When the receiver stalls, the output register holds its result, one more
// item is taken into the input register, and o_in_ready then drops until the
// result is taken.
// Depends on vqst_pkg, vqst_cfg and vqst_core.
`default_nettype none

module venue_quote_sync_table_top
    import vqst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic      [DATA_W-1:0]       prdata,
    output logic                         pready,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_req_type,
    input  wire logic [ID_W-1:0]         i_venue_key,
    input  wire logic [TS_W-1:0]         i_sample_time,
    input  wire logic [TS_W-1:0]         i_receipt_time,
    input  wire logic [TS_W-1:0]         i_exchange_time,
    input  wire logic signed [PX_W-1:0]  i_bid_ticks,
    input  wire logic signed [PX_W-1:0]  i_ask_ticks,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_venue_seen,
    output logic signed [PX_W-1:0]       o_stored_bid,
    output logic signed [PX_W-1:0]       o_stored_ask,
    output logic [TS_W-1:0]              o_stored_receipt,
    output logic [TS_W-1:0]              o_stored_exchange,
    output logic [TS_W-1:0]              o_stored_sample,
    output logic                         o_global_valid,
    output logic [TS_W-1:0]              o_global_sample
);

    t_cfg    cfg;
    t_item   n_in;
    t_item   r_in;
    logic    r_in_valid;
    t_result n_out;
    t_result r_out;
    logic    r_out_valid;
    logic    out_free;
    logic    advance;

    vqst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vqst_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (n_out)
    );

    assign n_in.req_type      = t_req'(i_req_type);
    assign n_in.venue_key     = i_venue_key;
    assign n_in.sample_time   = i_sample_time;
    assign n_in.receipt_time  = i_receipt_time;
    assign n_in.exchange_time = i_exchange_time;
    assign n_in.bid_ticks     = i_bid_ticks;
    assign n_in.ask_ticks     = i_ask_ticks;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= n_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out.status;
    assign o_venue_seen      = r_out.venue_seen;
    assign o_stored_bid      = r_out.stored_bid;
    assign o_stored_ask      = r_out.stored_ask;
    assign o_stored_receipt  = r_out.stored_receipt;
    assign o_stored_exchange = r_out.stored_exchange;
    assign o_stored_sample   = r_out.stored_sample;
    assign o_global_valid    = r_out.global_valid;
    assign o_global_sample   = r_out.global_sample;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input register dropped a stalled item");

    a_unknown_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_UNKNOWN))
            |-> (!o_venue_seen && (o_stored_bid == '0) && (o_stored_sample == '0)))
        else $error("unknown venue result carries slot data");

    a_seen_global: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_venue_seen) |-> o_global_valid)
        else $error("seen slot without any global update");

    a_ok_update_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.req_type == REQ_UPDATE) && (n_out.status == ST_OK))
            |=> (r_out.venue_seen && r_out.global_valid
                 && (r_out.global_sample == r_out.stored_sample)))
        else $error("accepted update not reflected in result");
`endif

endmodule

`default_nettype wire

// ===== verif/quote_table_checker.sv =====
// Checker for the venue quote sync table: monitors the APB port and both item
// channels, predicts each result from its own copy of the table and compares.
// Depends on vqst_pkg.
`timescale 1ns / 1ps

module quote_table_checker
    import vqst_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic                   pready,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic                   req_type,
    input  wire logic [ID_W-1:0]        venue_key,
    input  wire logic [TS_W-1:0]        sample_time,
    input  wire logic [TS_W-1:0]        receipt_time,
    input  wire logic [TS_W-1:0]        exchange_time,
    input  wire logic signed [PX_W-1:0] bid_ticks,
    input  wire logic signed [PX_W-1:0] ask_ticks,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire logic [1:0]             status,
    input  wire logic                   venue_seen,
    input  wire logic signed [PX_W-1:0] stored_bid,
    input  wire logic signed [PX_W-1:0] stored_ask,
    input  wire logic [TS_W-1:0]        stored_receipt,
    input  wire logic [TS_W-1:0]        stored_exchange,
    input  wire logic [TS_W-1:0]        stored_sample,
    input  wire logic                   global_valid,
    input  wire logic [TS_W-1:0]        global_sample,
    output int                          mismatch_count,
    output int                          pending_quotes
);

    logic [ID_W-1:0]        slot_venue    [NUM_SLOTS];
    logic [CNT_W-1:0]       slots_in_use;
    logic                   has_quote     [NUM_SLOTS];
    logic [TS_W-1:0]        last_receipt  [NUM_SLOTS];
    logic [TS_W-1:0]        last_exchange [NUM_SLOTS];
    logic [TS_W-1:0]        last_sample   [NUM_SLOTS];
    logic signed [PX_W-1:0] last_bid      [NUM_SLOTS];
    logic signed [PX_W-1:0] last_ask      [NUM_SLOTS];
    logic                   feed_started;
    logic [TS_W-1:0]        feed_latest;
    t_result                expected_quotes [$];
    int                     fails = 0;

    task automatic clear_table();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            slot_venue[s]    = ID_W'(s);
            has_quote[s]     = 1'b0;
            last_receipt[s]  = '0;
            last_exchange[s] = '0;
            last_sample[s]   = '0;
            last_bid[s]      = '0;
            last_ask[s]      = '0;
        end
        slots_in_use = CNT_W'(1);
        feed_started = 1'b0;
        feed_latest  = '0;
        expected_quotes.delete();
    endtask

    task automatic apply_reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        int idx;
        idx = int'(addr >> 2);
        if (idx == int'(REG_COUNT)) begin
            slots_in_use = data[CNT_W-1:0];
        end else if (idx < NUM_ID_REGS && idx < NUM_SLOTS) begin
            slot_venue[idx] = data[ID_W-1:0];
        end
    endtask

    task automatic predict_quote_result(input t_item rq, output t_result rs);
        int      hit;
        int      n;
        t_status st;
        hit = -1;
        n = (slots_in_use > NUM_SLOTS) ? NUM_SLOTS : int'(slots_in_use);
        for (int s = n - 1; s >= 0; s--) begin
            if (slot_venue[s] == rq.venue_key) hit = s;
        end
        if (rq.req_type == REQ_QUERY) begin
            st = (hit >= 0) ? ST_OK : ST_UNKNOWN;
        end else if (rq.receipt_time > rq.sample_time) begin
            st = ST_INVALID;
        end else if (feed_started && rq.sample_time < feed_latest) begin
            st = ST_ORDER;
        end else if (hit < 0) begin
            st = ST_UNKNOWN;
        end else if (has_quote[hit] && (rq.sample_time < last_sample[hit] ||
                                        rq.receipt_time < last_receipt[hit])) begin
            st = ST_ORDER;
        end else begin
            has_quote[hit]     = 1'b1;
            last_receipt[hit]  = rq.receipt_time;
            last_exchange[hit] = rq.exchange_time;
            last_sample[hit]   = rq.sample_time;
            last_bid[hit]      = rq.bid_ticks;
            last_ask[hit]      = rq.ask_ticks;
            feed_started       = 1'b1;
            feed_latest        = rq.sample_time;
            st = ST_OK;
        end
        rs = '0;
        rs.status = st;
        if (hit >= 0) begin
            rs.venue_seen      = has_quote[hit];
            rs.stored_bid      = last_bid[hit];
            rs.stored_ask      = last_ask[hit];
            rs.stored_receipt  = last_receipt[hit];
            rs.stored_exchange = last_exchange[hit];
            rs.stored_sample   = last_sample[hit];
        end
        rs.global_valid  = feed_started;
        rs.global_sample = feed_latest;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fails++;
        end
    endtask

    always @(posedge clk) begin : watch
        t_item   rq;
        t_result rs;
        if (!rst_n) begin
            clear_table();
        end else begin
            if (out_valid && out_ready) begin
                if (expected_quotes.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fails++;
                end else begin
                    rs = expected_quotes.pop_front();
                    check_field("status", rs.status, status);
                    check_field("venue_seen", rs.venue_seen, venue_seen);
                    check_field("stored_bid", rs.stored_bid, stored_bid);
                    check_field("stored_ask", rs.stored_ask, stored_ask);
                    check_field("stored_receipt", rs.stored_receipt, stored_receipt);
                    check_field("stored_exchange", rs.stored_exchange, stored_exchange);
                    check_field("stored_sample", rs.stored_sample, stored_sample);
                    check_field("global_valid", rs.global_valid, global_valid);
                    check_field("global_sample", rs.global_sample, global_sample);
                end
            end
            if (psel && penable && pwrite && pready) begin
                apply_reg_write(paddr, pwdata);
            end
            if (in_valid && in_ready) begin
                rq.req_type      = t_req'(req_type);
                rq.venue_key     = venue_key;
                rq.sample_time   = sample_time;
                rq.receipt_time  = receipt_time;
                rq.exchange_time = exchange_time;
                rq.bid_ticks     = bid_ticks;
                rq.ask_ticks     = ask_ticks;
                predict_quote_result(rq, rs);
                expected_quotes.insert(expected_quotes.size(), rs);
            end
        end
        mismatch_count <= fails;
        pending_quotes <= expected_quotes.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the venue quote sync table testbench: clock, reset, APB programming,
// directed and random update/query traffic with random stalls on both channels.
// Depends on vqst_pkg, venue_quote_sync_table_top and quote_table_checker.
`timescale 1ns / 1ps

module tb_top;
    import vqst_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 100;
    localparam logic [NUM_PHASES-1:0][CNT_W-1:0] PHASE_COUNTS =
        {3'd3, 3'd2, 3'd7, 3'd0, 3'd4};
    localparam logic [TS_W-1:0]        TS_MAX = {TS_W{1'b1}};
    localparam logic signed [PX_W-1:0] PX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PX_W-1:0] PX_MIN = 32'sh8000_0000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_W-1:0]      paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_item                  offer;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [1:0]             o_status;
    logic                   o_venue_seen;
    logic signed [PX_W-1:0] o_stored_bid;
    logic signed [PX_W-1:0] o_stored_ask;
    logic [TS_W-1:0]        o_stored_receipt;
    logic [TS_W-1:0]        o_stored_exchange;
    logic [TS_W-1:0]        o_stored_sample;
    logic                   o_global_valid;
    logic [TS_W-1:0]        o_global_sample;

    int                               mismatch_count;
    int                               pending_quotes;
    int                               idle_cycles = 0;
    logic                             tx_gaps = 1'b1;
    logic                             rx_gaps = 1'b1;
    logic                             hold_request = 1'b0;
    logic [NUM_ID_REGS-1:0][ID_W-1:0] slot_keys;
    int                               active_keys;
    logic [TS_W-1:0]                  feed_ns;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    venue_quote_sync_table_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_req_type        (offer.req_type),
        .i_venue_key       (offer.venue_key),
        .i_sample_time     (offer.sample_time),
        .i_receipt_time    (offer.receipt_time),
        .i_exchange_time   (offer.exchange_time),
        .i_bid_ticks       (offer.bid_ticks),
        .i_ask_ticks       (offer.ask_ticks),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_venue_seen      (o_venue_seen),
        .o_stored_bid      (o_stored_bid),
        .o_stored_ask      (o_stored_ask),
        .o_stored_receipt  (o_stored_receipt),
        .o_stored_exchange (o_stored_exchange),
        .o_stored_sample   (o_stored_sample),
        .o_global_valid    (o_global_valid),
        .o_global_sample   (o_global_sample)
    );

    quote_table_checker u_checker (
        .clk             (i_clk),
        .rst_n           (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (i_in_valid),
        .in_ready        (o_in_ready),
        .req_type        (offer.req_type),
        .venue_key       (offer.venue_key),
        .sample_time     (offer.sample_time),
        .receipt_time    (offer.receipt_time),
        .exchange_time   (offer.exchange_time),
        .bid_ticks       (offer.bid_ticks),
        .ask_ticks       (offer.ask_ticks),
        .out_valid       (o_out_valid),
        .out_ready       (i_out_ready),
        .status          (o_status),
        .venue_seen      (o_venue_seen),
        .stored_bid      (o_stored_bid),
        .stored_ask      (o_stored_ask),
        .stored_receipt  (o_stored_receipt),
        .stored_exchange (o_stored_exchange),
        .stored_sample   (o_stored_sample),
        .global_valid    (o_global_valid),
        .global_sample   (o_global_sample),
        .mismatch_count  (mismatch_count),
        .pending_quotes  (pending_quotes)
    );

    function automatic logic [TS_W-1:0] rand_ts();
        return TS_W'({$urandom, $urandom});
    endfunction

    function automatic t_item quote_req(input t_req kind, input logic [ID_W-1:0] key,
                                        input logic [TS_W-1:0] samp,
                                        input logic [TS_W-1:0] rcpt,
                                        input logic [TS_W-1:0] exch,
                                        input logic signed [PX_W-1:0] bid,
                                        input logic signed [PX_W-1:0] ask);
        t_item rq;
        rq.req_type      = kind;
        rq.venue_key     = key;
        rq.sample_time   = samp;
        rq.receipt_time  = rcpt;
        rq.exchange_time = exch;
        rq.bid_ticks     = bid;
        rq.ask_ticks     = ask;
        return rq;
    endfunction

    function automatic logic [ID_W-1:0] pick_key();
        if (active_keys == 0 || $urandom_range(9) == 0) return ID_W'($urandom);
        return slot_keys[$urandom_range(active_keys - 1)];
    endfunction

    // mostly in-order quotes on configured venues, plus stale, invalid,
    // unknown-venue and query traffic
    function automatic t_item random_quote_req();
        t_item rq;
        int    roll;
        roll             = $urandom_range(99);
        rq.req_type      = REQ_UPDATE;
        rq.venue_key     = pick_key();
        rq.exchange_time = rand_ts();
        rq.bid_ticks     = $urandom;
        rq.ask_ticks     = $urandom;
        if (roll < 55) begin
            feed_ns += $urandom_range(400);
            rq.sample_time  = feed_ns;
            rq.receipt_time = feed_ns - $urandom_range(600);
        end else if (roll < 65) begin
            rq.sample_time  = feed_ns - $urandom_range(50, 1);
            rq.receipt_time = rq.sample_time - $urandom_range(100);
        end else if (roll < 73) begin
            rq.receipt_time = rand_ts() | TS_W'(1);
            rq.sample_time  = rand_ts() % rq.receipt_time;
        end else if (roll < 80) begin
            rq.venue_key    = ID_W'($urandom);
            rq.sample_time  = feed_ns;
            rq.receipt_time = feed_ns;
        end else begin
            rq.req_type     = REQ_QUERY;
            rq.sample_time  = rand_ts();
            rq.receipt_time = rand_ts();
        end
        return rq;
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_venue_map(input logic [NUM_ID_REGS-1:0][ID_W-1:0] ids,
                                  input logic [CNT_W-1:0] cnt);
        for (int s = 0; s < NUM_ID_REGS; s++) begin
            write_reg(t_reg_idx'(REG_ID0 + s), DATA_W'(ids[s]));
        end
        write_reg(REG_COUNT, DATA_W'(cnt));
        slot_keys   = ids;
        active_keys = (cnt > NUM_ID_REGS) ? NUM_ID_REGS : int'(cnt);
    endtask

    task automatic send_quote_req(input t_item rq);
        while (tx_gaps && $urandom_range(99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        offer      <= rq;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_quotes != 0) @(posedge i_clk);
    endtask

    initial begin : sink
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= !(rx_gaps && $urandom_range(99) < 37);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        logic [NUM_ID_REGS-1:0][ID_W-1:0] ids;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        offer      <= '0;
        slot_keys   = {8'd3, 8'd2, 8'd1, 8'd0};
        active_keys = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_quote_req(quote_req(REQ_QUERY,  8'h00, 0, 0, 0, 0, 0));
        send_quote_req(quote_req(REQ_QUERY,  8'h01, 0, 0, 0, 0, 0));
        send_quote_req(quote_req(REQ_UPDATE, 8'h00, 10, 11, 0, 0, 0));
        send_quote_req(quote_req(REQ_UPDATE, 8'h00, 5, 5, 0, 0, 0));
        send_quote_req(quote_req(REQ_UPDATE, 8'h01, 6, 6, 0, 0, 0));
        drain_results();
        load_venue_map({8'h5A, 8'h5A, 8'hFF, 8'h00}, CNT_W'(4));
        send_quote_req(quote_req(REQ_UPDATE, 8'hFF, 100, 100, TS_MAX, PX_MIN, PX_MAX));
        send_quote_req(quote_req(REQ_UPDATE, 8'h5A, 200, 50, 1, PX_MAX, PX_MIN));
        send_quote_req(quote_req(REQ_QUERY,  8'h5A, 0, 0, 0, 0, 0));
        send_quote_req(quote_req(REQ_UPDATE, 8'h00, 150, 150, 7, 1, 2));
        send_quote_req(quote_req(REQ_UPDATE, 8'h33, 300, 300, 7, 1, 2));
        send_quote_req(quote_req(REQ_UPDATE, 8'h33, 10, 0, 7, 1, 2));
        send_quote_req(quote_req(REQ_UPDATE, 8'h33, 400, 401, 7, 1, 2));
        send_quote_req(quote_req(REQ_UPDATE, 8'h5A, 300, 40, 7, 1, 2));
        send_quote_req(quote_req(REQ_UPDATE, 8'h5A, 200, 50, 9, -1, -2));
        send_quote_req(quote_req(REQ_UPDATE, 8'hFF, 200, 100, 3, -5, 5));
        send_quote_req(quote_req(REQ_QUERY,  8'hFF, TS_MAX, TS_MAX, TS_MAX, PX_MIN, PX_MIN));
        send_quote_req(quote_req(REQ_QUERY,  8'h00, 0, TS_MAX, 0, 0, 0));
        send_quote_req(quote_req(REQ_QUERY,  8'h33, 0, 0, 0, 0, 0));

        feed_ns = (rand_ts() >> 4) | (TS_W'(1) << 59);
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            if (p == 0) begin
                ids = {8'h80, 8'h01, 8'hFF, 8'h00};
            end else begin
                ids = $urandom;
                if (p == 3) ids[1] = ids[0];
            end
            load_venue_map(ids, PHASE_COUNTS[p]);
            tx_gaps = (p != 2);
            rx_gaps = (p != 2);
            if (p == 3) hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) send_quote_req(random_quote_req());
        end

        drain_results();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        load_venue_map({8'h03, 8'h02, 8'h01, 8'h00}, CNT_W'(4));
        send_quote_req(quote_req(REQ_UPDATE, 8'h00, TS_MAX, TS_MAX, TS_MAX, PX_MAX, PX_MAX));
        send_quote_req(quote_req(REQ_UPDATE, 8'h01, TS_MAX - 1, 0, 0, 0, 0));
        send_quote_req(quote_req(REQ_UPDATE, 8'h00, TS_MAX, 0, 0, 0, 0));
        send_quote_req(quote_req(REQ_UPDATE, 8'h02, TS_MAX, TS_MAX, 0, PX_MIN, PX_MIN));
        send_quote_req(quote_req(REQ_QUERY,  8'h00, 0, 0, 0, 0, 0));

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/vqst_pkg.sv
sv/vqst_cfg.sv
sv/vqst_core.sv
sv/venue_quote_sync_table_top.sv
verif/quote_table_checker.sv
verif/tb_top.sv
